>>> rtl/fwtd_pkg.sv
// Shared types and constants for the force window trigger debounce core.
// No dependencies; used by force_window_trigger_debounce_core.
package fwtd_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_TARE      = 3'd1,
    REG_NEEDED    = 3'd2,
    REG_WD_LIMIT  = 3'd3,
    REG_REASON    = 3'd4
  } reg_index_t;

  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int S_TDATA_W   = 64;
  localparam int M_TDATA_W   = 112;

  localparam logic [COUNT_W-1:0] COUNTDOWN_RESET = 8'd2;
  localparam logic [COUNT_W-1:0] NEEDED_RESET    = 8'd2;
  localparam logic [COUNT_W-1:0] SILENCE_MAX     = 8'hFF;

  typedef struct packed {
    logic [2:0]  pad;
    logic        timeout_fault;
    logic [31:0] latest_sample_time;
    logic [31:0] latest_sample;
    logic [31:0] trigger_time;
    logic [7:0]  fire_code;
    logic        trigger_pulse;
    logic        homing_latched;
    logic        homing_active;
    logic        live_triggered;
  } result_t;

endpackage

>>> rtl/force_window_trigger_debounce_core.sv
// Load-cell endstop: window comparator with consecutive-sample debounce.
// Depends on fwtd_pkg for command codes, register indexes and the result layout.
//
// Usage:
//   Requests enter on s_tvalid/s_tready with the command in s_tuser and the
//   sample and its time stamp in s_tdata. Every request yields exactly one
//   result on m_tvalid/m_tready, showing the state after that request.
//   The user must write registers through cfg_we/cfg_index/cfg_data only while
//   idle; the block does not check. An index beyond the register list is dropped.
// Pipeline and throughput:
//   A request is held in an input register, evaluated against the window
//   and the debounce state, and lands in the result register, which
//   raises m_tvalid. One request per cycle is taken as long as the result
//   register drains; the single comparison and countdown step between the
//   two registers sets that rate.
// Reset:
//   rst (synchronous) empties both registers, restores the countdown to 2,
//   samples_needed to 2 and clears all flags and captured values.
// Stall:
//   When m_tready is low the result holds; the input register still accepts
//   one request, then s_tready drops until the result is taken.
module force_window_trigger_debounce_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fwtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fwtd_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] sample, [63:32] time_stamp
  input  logic [fwtd_pkg::S_TDATA_W-1:0]      s_tdata,
  // [1:0] command
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] live_triggered, [1] homing_active, [2] homing_latched, [3] trigger_pulse,
  // [11:4] fire_code, [43:12] trigger_time, [75:44] latest_sample,
  // [107:76] latest_sample_time, [108] timeout_fault, [111:109] zero
  output logic [fwtd_pkg::M_TDATA_W-1:0]      m_tdata
);

  logic [31:0] trigger_threshold;
  logic [31:0] tare_value;
  logic [7:0]  samples_needed;
  logic [7:0]  watchdog_limit;
  logic [7:0]  reason_code;

  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [31:0] in_sample;
  logic [31:0] in_time;

  logic        live_flag, live_flag_next;
  logic        homing_flag, homing_flag_next;
  logic        latched_flag, latched_flag_next;
  logic [7:0]  countdown, countdown_next;
  logic [31:0] capture_time, capture_time_next;
  logic [31:0] last_value, last_value_next;
  logic [31:0] last_value_time, last_value_time_next;
  logic [7:0]  silence_count, silence_count_next;
  logic        fault_flag, fault_flag_next;
  logic        pulse;

  fwtd_pkg::result_t result;
  logic        move;

  logic [7:0]  needed;
  logic signed [33:0] s_ext, win_hi, win_lo;
  logic        out_win;
  logic        armed;

  assign move     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_threshold <= '0;
      tare_value        <= '0;
      samples_needed    <= fwtd_pkg::NEEDED_RESET;
      watchdog_limit    <= '0;
      reason_code       <= '0;
    end else if (cfg_we) begin
      case (fwtd_pkg::reg_index_t'(cfg_index))
        fwtd_pkg::REG_THRESHOLD: trigger_threshold <= cfg_data;
        fwtd_pkg::REG_TARE:      tare_value        <= cfg_data;
        fwtd_pkg::REG_NEEDED:    samples_needed    <= cfg_data[7:0];
        fwtd_pkg::REG_WD_LIMIT:  watchdog_limit    <= cfg_data[7:0];
        fwtd_pkg::REG_REASON:    reason_code       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd    <= s_tuser;
      in_sample <= s_tdata[31:0];
      in_time   <= s_tdata[63:32];
    end
  end

  assign needed = (samples_needed == 8'd0) ? 8'd1 : samples_needed;
  assign s_ext  = {{2{in_sample[31]}}, in_sample};
  assign win_hi = {{2{tare_value[31]}}, tare_value} + {2'b00, trigger_threshold};
  assign win_lo = {{2{tare_value[31]}}, tare_value} - {2'b00, trigger_threshold};
  assign out_win = (s_ext >= win_hi) || (s_ext <= win_lo);
  assign armed   = homing_flag && !latched_flag;

  always_comb begin
    live_flag_next       = live_flag;
    homing_flag_next     = homing_flag;
    latched_flag_next    = latched_flag;
    countdown_next       = countdown;
    capture_time_next    = capture_time;
    last_value_next      = last_value;
    last_value_time_next = last_value_time;
    silence_count_next   = silence_count;
    fault_flag_next      = fault_flag;
    pulse                = 1'b0;
    case (fwtd_pkg::cmd_t'(in_cmd))
      fwtd_pkg::CMD_SAMPLE: begin
        last_value_next      = in_sample;
        last_value_time_next = in_time;
        silence_count_next   = '0;
        if (out_win && countdown != 8'd0) begin
          if (armed && countdown == needed) begin
            capture_time_next = in_time;
          end
          countdown_next = countdown - 8'd1;
          if (countdown == 8'd1) begin
            live_flag_next = 1'b1;
            if (armed) begin
              latched_flag_next = 1'b1;
              pulse             = 1'b1;
            end
          end
        end else if (!out_win && countdown < needed) begin
          countdown_next = needed;
          live_flag_next = 1'b0;
          if (armed) begin
            capture_time_next = '0;
          end
        end
      end
      fwtd_pkg::CMD_TICK: begin
        if (armed) begin
          if (silence_count > watchdog_limit) begin
            fault_flag_next = 1'b1;
          end
          if (silence_count != fwtd_pkg::SILENCE_MAX) begin
            silence_count_next = silence_count + 8'd1;
          end
        end
      end
      fwtd_pkg::CMD_START: begin
        capture_time_next  = '0;
        latched_flag_next  = 1'b0;
        homing_flag_next   = 1'b1;
        silence_count_next = '0;
      end
      default: begin
        capture_time_next = '0;
        latched_flag_next = 1'b0;
        homing_flag_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_flag       <= 1'b0;
      homing_flag     <= 1'b0;
      latched_flag    <= 1'b0;
      countdown       <= fwtd_pkg::COUNTDOWN_RESET;
      capture_time    <= '0;
      last_value      <= '0;
      last_value_time <= '0;
      silence_count   <= '0;
      fault_flag      <= 1'b0;
    end else if (move) begin
      live_flag       <= live_flag_next;
      homing_flag     <= homing_flag_next;
      latched_flag    <= latched_flag_next;
      countdown       <= countdown_next;
      capture_time    <= capture_time_next;
      last_value      <= last_value_next;
      last_value_time <= last_value_time_next;
      silence_count   <= silence_count_next;
      fault_flag      <= fault_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result.pad                <= '0;
      result.timeout_fault      <= fault_flag_next;
      result.latest_sample_time <= last_value_time_next;
      result.latest_sample      <= last_value_next;
      result.trigger_time       <= capture_time_next;
      result.fire_code          <= pulse ? reason_code : 8'd0;
      result.trigger_pulse      <= pulse;
      result.homing_latched     <= latched_flag_next;
      result.homing_active      <= homing_flag_next;
      result.live_triggered     <= live_flag_next;
    end
  end

  assign m_tdata = result;

  a_live_matches_countdown: assert property (@(posedge clk) disable iff (rst)
    live_flag == (countdown == 8'd0))
    else $error("live flag out of step with countdown");

  a_latch_needs_homing: assert property (@(posedge clk) disable iff (rst)
    latched_flag |-> homing_flag)
    else $error("latched without homing");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("fault flag cleared without reset");

  a_pulse_latches: assert property (@(posedge clk) disable iff (rst)
    (move && pulse) |=> (latched_flag && m_tvalid && result.homing_latched))
    else $error("trigger pulse without latch");

endmodule
